/* sv/ghal_pkg.sv */
`timescale 1ns / 1ps

package ghal_pkg;

    typedef enum logic [1:0] {
        REQ_CREATE  = 2'd0,
        REQ_DESTROY = 2'd1,
        REQ_CHECK   = 2'd2,
        REQ_EOF     = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_GEN,
        S_EVAL,
        S_EOF
    } t_state;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SLOT    = 2'd1;
    localparam logic [1:0] ST_BAD_HANDLE = 2'd2;

    localparam int CFG_W       = 11;
    localparam int IDX_W       = 10;
    localparam int GEN_W       = 16;
    localparam int FREED_W     = 11;
    localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 11'd1024;

endpackage

/* sv/ghal_ram.sv */
`timescale 1ns / 1ps

module ghal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/generational_handle_allocator_unit.sv */
`timescale 1ns / 1ps
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+----------------------------
// request   | i_req_type, i_handle_index, i_handle_generation    | taken when start && !busy
// result    | o_status, o_slot_index, o_slot_generation,         | o_strobe, one cycle, no stall
//           | o_is_valid, o_freed_count                          |
// config    | i_cfg_wdata (slot count)                           | i_cfg_we, written at once
//
// Destroy and check read the generation, then compare (destroy writes it back); create reads
// the free stack first, then the generation of the popped slot.
// End of frame moves one pending entry per cycle over the index memory's read and
// write ports. After reset and after every slot count write a clearing pass over all
// MAX_SLOTS slots (1024 at default) rewrites generations and the free stack; busy stays
// high meanwhile.
// The result strobe comes in the first cycle with busy low; the receiver cannot stall it.

module generational_handle_allocator_unit
    import ghal_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    parameter int GEN_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [IDX_W-1:0]   i_handle_index,
    input  logic [GEN_W-1:0]   i_handle_generation,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic [IDX_W-1:0]   o_slot_index,
    output logic [GEN_W-1:0]   o_slot_generation,
    output logic               o_is_valid,
    output logic [FREED_W-1:0] o_freed_count
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int GW = GEN_BITS;
    localparam int AW = (CW > CFG_W) ? CW : CFG_W;

    function automatic logic [CW-1:0] active_of(input logic [CFG_W-1:0] count);
        logic [CW-1:0] res;
        if (AW'(count) > AW'(MAX_SLOTS)) begin
            res = CW'(MAX_SLOTS);
        end else begin
            res = CW'(count);
        end
        return res;
    endfunction

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [IW-1:0]     r_idx, n_idx;
    logic [GW-1:0]     r_gen, n_gen;
    logic              r_fail, n_fail;
    logic [IW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_active, n_active;
    logic [CW-1:0]     r_free_depth, n_free_depth;
    logic [CW-1:0]     r_pend_depth, n_pend_depth;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic              r_rd_pend, n_rd_pend;
    logic [CW-1:0]     r_freed, n_freed;
    logic [IW-1:0]     r_clr, n_clr;

    logic              r_strobe, n_strobe;
    logic [1:0]        r_status, n_status;
    logic [IDX_W-1:0]  r_slot_index, n_slot_index;
    logic [GEN_W-1:0]  r_slot_gen, n_slot_gen;
    logic              r_valid, n_valid;
    logic [FREED_W-1:0] r_freed_out, n_freed_out;

    logic              gen_we;
    logic [IW-1:0]     gen_waddr;
    logic [GW-1:0]     gen_wdata;
    logic [IW-1:0]     gen_raddr;
    logic [GW-1:0]     gen_rdata;

    logic              idx_we;
    logic [IW:0]       idx_waddr;
    logic [IW-1:0]     idx_wdata;
    logic [IW:0]       idx_raddr;
    logic [IW-1:0]     idx_rdata;

    logic [CW-1:0]     dec_depth;
    logic              hit;
    logic              more_reads;

    ghal_ram #(
        .WIDTH (GW),
        .DEPTH (MAX_SLOTS)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata)
    );

    // lower half: free stack, upper half: pending list
    ghal_ram #(
        .WIDTH (IW),
        .DEPTH (2 * (1 << IW))
    ) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (idx_waddr),
        .i_wdata (idx_wdata),
        .i_raddr (idx_raddr),
        .o_rdata (idx_rdata)
    );

    assign busy       = (r_state != S_IDLE);
    assign dec_depth  = r_free_depth - CW'(1);
    assign hit        = !r_fail && (gen_rdata == r_gen);
    assign more_reads = (r_ptr < r_pend_depth);

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_gen        = r_gen;
        n_fail       = r_fail;
        n_slot       = r_slot;
        n_active     = r_active;
        n_free_depth = r_free_depth;
        n_pend_depth = r_pend_depth;
        n_ptr        = r_ptr;
        n_rd_pend    = r_rd_pend;
        n_freed      = r_freed;
        n_clr        = r_clr;
        n_strobe     = 1'b0;
        n_status     = r_status;
        n_slot_index = r_slot_index;
        n_slot_gen   = r_slot_gen;
        n_valid      = r_valid;
        n_freed_out  = r_freed_out;

        gen_we    = 1'b0;
        gen_waddr = r_idx;
        gen_wdata = '0;
        gen_raddr = IW'(i_handle_index);
        idx_we    = 1'b0;
        idx_waddr = '0;
        idx_wdata = '0;
        idx_raddr = {1'b0, dec_depth[IW-1:0]};

        case (r_state)
            S_CLEAR: begin
                gen_we    = 1'b1;
                gen_waddr = r_clr;
                gen_wdata = '0;
                idx_we    = 1'b1;
                idx_waddr = {1'b0, r_clr};
                idx_wdata = r_clr;
                n_clr     = r_clr + IW'(1);
                if (r_clr == IW'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req     = t_req'(i_req_type);
                    n_idx     = IW'(i_handle_index);
                    n_gen     = GW'(i_handle_generation);
                    n_ptr     = '0;
                    n_freed   = '0;
                    n_rd_pend = 1'b0;
                    case (t_req'(i_req_type))
                        REQ_CREATE: begin
                            n_fail  = (r_free_depth == '0);
                            n_state = (r_free_depth == '0) ? S_EVAL : S_GEN;
                        end
                        REQ_DESTROY, REQ_CHECK: begin
                            n_fail  = !(AW'(i_handle_index) < AW'(r_active));
                            n_state = S_EVAL;
                        end
                        REQ_EOF: begin
                            n_fail  = 1'b0;
                            n_state = S_EOF;
                        end
                        default: begin
                            n_state = S_EVAL;
                        end
                    endcase
                end
            end
            S_GEN: begin
                gen_raddr    = idx_rdata;
                n_slot       = idx_rdata;
                n_free_depth = dec_depth;
                n_state      = S_EVAL;
            end
            S_EVAL: begin
                n_strobe     = 1'b1;
                n_status     = ST_OK;
                n_slot_index = '0;
                n_slot_gen   = '0;
                n_valid      = 1'b0;
                n_freed_out  = '0;
                n_state      = S_IDLE;
                case (r_req)
                    REQ_CREATE: begin
                        if (r_fail) begin
                            n_status = ST_NO_SLOT;
                        end else begin
                            n_slot_index = IDX_W'(r_slot);
                            n_slot_gen   = GEN_W'(gen_rdata);
                        end
                    end
                    REQ_DESTROY: begin
                        if (hit) begin
                            n_valid   = 1'b1;
                            gen_we    = 1'b1;
                            gen_waddr = r_idx;
                            gen_wdata = gen_rdata + GW'(1);
                            if (r_pend_depth < CW'(MAX_SLOTS)) begin
                                idx_we       = 1'b1;
                                idx_waddr    = {1'b1, r_pend_depth[IW-1:0]};
                                idx_wdata    = r_idx;
                                n_pend_depth = r_pend_depth + CW'(1);
                            end
                        end else begin
                            n_status = ST_BAD_HANDLE;
                        end
                    end
                    REQ_CHECK: begin
                        n_valid = hit;
                    end
                    default: begin
                    end
                endcase
            end
            S_EOF: begin
                if (more_reads) begin
                    idx_raddr = {1'b1, r_ptr[IW-1:0]};
                    n_ptr     = r_ptr + CW'(1);
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                end
                // push the entry read last cycle; drop it when the stack is full
                if (r_rd_pend && (r_free_depth < CW'(MAX_SLOTS))) begin
                    idx_we       = 1'b1;
                    idx_waddr    = {1'b0, r_free_depth[IW-1:0]};
                    idx_wdata    = idx_rdata;
                    n_free_depth = r_free_depth + CW'(1);
                    n_freed      = r_freed + CW'(1);
                end
                if (!more_reads && !r_rd_pend) begin
                    n_pend_depth = '0;
                    n_strobe     = 1'b1;
                    n_status     = ST_OK;
                    n_slot_index = '0;
                    n_slot_gen   = '0;
                    n_valid      = 1'b0;
                    n_freed_out  = FREED_W'(r_freed);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_active     = active_of(i_cfg_wdata);
            n_free_depth = active_of(i_cfg_wdata);
            n_pend_depth = '0;
            n_clr        = '0;
            n_state      = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_active     <= active_of(SLOT_COUNT_RESET);
            r_free_depth <= active_of(SLOT_COUNT_RESET);
            r_pend_depth <= '0;
            r_rd_pend    <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_active     <= n_active;
            r_free_depth <= n_free_depth;
            r_pend_depth <= n_pend_depth;
            r_rd_pend    <= n_rd_pend;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_gen        <= n_gen;
        r_fail       <= n_fail;
        r_slot       <= n_slot;
        r_ptr        <= n_ptr;
        r_freed      <= n_freed;
        r_status     <= n_status;
        r_slot_index <= n_slot_index;
        r_slot_gen   <= n_slot_gen;
        r_valid      <= n_valid;
        r_freed_out  <= n_freed_out;
    end

    assign o_strobe          = r_strobe;
    assign o_status          = r_status;
    assign o_slot_index      = r_slot_index;
    assign o_slot_generation = r_slot_gen;
    assign o_is_valid        = r_valid;
    assign o_freed_count     = r_freed_out;

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_depth <= CW'(MAX_SLOTS))
        else $error("free stack depth above slot capacity");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_depth <= CW'(MAX_SLOTS))
        else $error("pending depth above slot capacity");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !o_strobe)
        else $error("result during clearing pass");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_valid) |-> (o_status == ST_OK))
        else $error("valid handle reported with error status");

    a_no_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_NO_SLOT)) |-> ($past(r_free_depth) == '0))
        else $error("no-slot status with nonempty free stack");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb
    import ghal_pkg::*;
();

    localparam int SLOTS = 1024;

    typedef enum logic [1:0] {
        PICK_RAW,
        PICK_LIVE,
        PICK_STALE,
        PICK_MATCH
    } t_pick;

    typedef struct {
        t_req             req;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        t_pick            pick;
    } t_alloc_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   slot;
        logic [GEN_W-1:0]   gen;
        logic               valid;
        logic [FREED_W-1:0] freed;
    } t_alloc_result;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_req_type = '0;
    logic [IDX_W-1:0]   i_handle_index = '0;
    logic [GEN_W-1:0]   i_handle_generation = '0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [IDX_W-1:0]   o_slot_index;
    logic [GEN_W-1:0]   o_slot_generation;
    logic               o_is_valid;
    logic [FREED_W-1:0] o_freed_count;

    logic [GEN_W-1:0] gen_mem [SLOTS];
    logic [IDX_W-1:0] free_stk [SLOTS];
    logic [IDX_W-1:0] retire_list [SLOTS];
    int unsigned      free_cnt;
    int unsigned      retire_cnt;
    int unsigned      slot_limit;
    logic [IDX_W-1:0] issued_handles [$];

    t_alloc_req    handle_requests [$];
    t_alloc_result expected_replies [$];
    t_alloc_req    cur_req;
    t_alloc_result want;
    bit            steady = 1'b0;
    int unsigned   err_count = 0;

    generational_handle_allocator_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_handle_index     (i_handle_index),
        .i_handle_generation(i_handle_generation),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_slot_index       (o_slot_index),
        .o_slot_generation  (o_slot_generation),
        .o_is_valid         (o_is_valid),
        .o_freed_count      (o_freed_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void restart_allocator(int unsigned count);
        slot_limit = (count > SLOTS) ? SLOTS : count;
        for (int i = 0; i < SLOTS; i++) begin
            gen_mem[i] = '0;
            free_stk[i] = IDX_W'(i);
        end
        free_cnt = slot_limit;
        retire_cnt = 0;
        issued_handles.delete();
    endfunction

    function automatic bit handle_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
        return (idx < slot_limit) && (gen_mem[idx] == gen);
    endfunction

    function automatic void run_allocator(t_alloc_req r);
        t_alloc_result e;
        bit            found;
        e = '0;
        found = 1'b0;
        case (r.req)
            REQ_CREATE: begin
                if (free_cnt == 0) begin
                    e.status = ST_NO_SLOT;
                end else begin
                    free_cnt--;
                    e.slot = free_stk[free_cnt];
                    e.gen = gen_mem[e.slot];
                    issued_handles = {issued_handles, e.slot};
                end
            end
            REQ_DESTROY: begin
                if (!handle_live(r.idx, r.gen)) begin
                    e.status = ST_BAD_HANDLE;
                end else begin
                    e.valid = 1'b1;
                    gen_mem[r.idx] = gen_mem[r.idx] + 1'b1;
                    if (retire_cnt < SLOTS) begin
                        retire_list[retire_cnt] = r.idx;
                        retire_cnt++;
                    end
                    for (int i = 0; i < issued_handles.size() && !found; i++) begin
                        if (issued_handles[i] == r.idx) begin
                            issued_handles.delete(i);
                            found = 1'b1;
                        end
                    end
                end
            end
            REQ_CHECK: begin
                e.valid = handle_live(r.idx, r.gen);
            end
            default: begin
                for (int i = 0; i < retire_cnt; i++) begin
                    if (free_cnt < SLOTS) begin
                        free_stk[free_cnt] = retire_list[i];
                        free_cnt++;
                        e.freed = e.freed + 1'b1;
                    end
                end
                retire_cnt = 0;
            end
        endcase
        expected_replies = {expected_replies, e};
    endfunction

    function automatic t_alloc_req bind_handle(t_alloc_req r);
        int unsigned pos;
        if (r.pick == PICK_MATCH) begin
            r.gen = gen_mem[r.idx];
        end else if (r.pick != PICK_RAW && issued_handles.size() != 0) begin
            pos = $urandom_range(issued_handles.size() - 1);
            r.idx = issued_handles[pos];
            r.gen = gen_mem[r.idx];
            if (r.pick == PICK_STALE) begin
                r.gen = r.gen - 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void queue_req(t_req req, logic [IDX_W-1:0] idx,
                                      logic [GEN_W-1:0] gen, t_pick pick);
        t_alloc_req r;
        r.req = req;
        r.idx = idx;
        r.gen = gen;
        r.pick = pick;
        handle_requests = {handle_requests, r};
    endfunction

    function automatic t_alloc_req random_request();
        t_alloc_req  r;
        int unsigned roll;
        roll = $urandom_range(99);
        r.idx = IDX_W'($urandom_range(1023));
        r.gen = GEN_W'($urandom_range(65535));
        r.pick = PICK_LIVE;
        r.req = REQ_CHECK;
        if (roll < 28) begin
            r.req = REQ_CREATE;
            r.pick = PICK_RAW;
        end else if (roll < 40) begin
            r.req = REQ_CHECK;
        end else if (roll < 56) begin
            r.req = REQ_DESTROY;
        end else if (roll < 62) begin
            r.req = REQ_DESTROY;
            r.pick = PICK_STALE;
        end else if (roll < 66) begin
            r.pick = PICK_STALE;
        end else if (roll < 71) begin
            r.req = REQ_DESTROY;
            r.pick = PICK_MATCH;
            if (slot_limit > 0) begin
                r.idx = IDX_W'($urandom_range(slot_limit - 1));
            end
        end else if (roll < 80) begin
            r.req = REQ_EOF;
            r.pick = PICK_RAW;
        end else begin
            r.req = t_req'($urandom_range(3));
            r.pick = PICK_RAW;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
        err_count++;
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (handle_requests.size() != 0 || start || busy || expected_replies.size() != 0);
    endtask

    task automatic write_slot_count(logic [CFG_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        restart_allocator(value);
        while (!busy) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // driver: hold the item until taken, then advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                run_allocator(cur_req);
            end
            if (start && busy) begin
            end else if (handle_requests.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
                cur_req = bind_handle(handle_requests.pop_front());
                start <= 1'b1;
                i_req_type <= cur_req.req;
                i_handle_index <= cur_req.idx;
                i_handle_generation <= cur_req.gen;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("result with nothing pending, status", o_status, 0);
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_slot_index !== want.slot)
                    report_mismatch("slot_index", o_slot_index, want.slot);
                if (o_slot_generation !== want.gen)
                    report_mismatch("slot_generation", o_slot_generation, want.gen);
                if (o_is_valid !== want.valid)
                    report_mismatch("is_valid", o_is_valid, want.valid);
                if (o_freed_count !== want.freed)
                    report_mismatch("freed_count", o_freed_count, want.freed);
            end
        end
    end

    initial begin
        int unsigned phase_count [10];
        int unsigned phase_items [10];
        phase_count = '{4, 1024, 2, 2047, 1, 33, 0, 1500, 9, 600};
        phase_items = '{60, 120, 40, 60, 30, 60, 10, 50, 60, 40};
        phase_count[9] = $urandom_range(2047, 1);
        restart_allocator(SLOT_COUNT_RESET);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full count: pops, stale handles, destroy of a free slot, stack overflow at frame end
        queue_req(REQ_CREATE, '0, '0, PICK_RAW);
        queue_req(REQ_CHECK, '0, '0, PICK_LIVE);
        queue_req(REQ_CHECK, 10'd1023, 16'hFFFF, PICK_RAW);
        queue_req(REQ_DESTROY, 10'd1023, '0, PICK_MATCH);
        queue_req(REQ_CHECK, 10'd1023, '0, PICK_RAW);
        queue_req(REQ_DESTROY, 10'd1023, '0, PICK_RAW);
        queue_req(REQ_DESTROY, 10'd0, '0, PICK_RAW);
        queue_req(REQ_EOF, '0, '0, PICK_RAW);
        queue_req(REQ_CREATE, '0, '0, PICK_RAW);
        queue_req(REQ_CREATE, '0, '0, PICK_RAW);
        queue_req(REQ_DESTROY, 10'd1023, 16'd1, PICK_RAW);
        queue_req(REQ_EOF, '0, '0, PICK_RAW);
        queue_req(REQ_CHECK, 10'd0, 16'd1, PICK_RAW);
        queue_req(REQ_CHECK, 10'd1023, 16'd2, PICK_RAW);

        // no slots at all
        write_slot_count(11'd0);
        queue_req(REQ_CREATE, '0, '0, PICK_RAW);
        queue_req(REQ_CHECK, 10'd0, '0, PICK_RAW);
        queue_req(REQ_DESTROY, 10'd0, '0, PICK_RAW);
        queue_req(REQ_EOF, '0, '0, PICK_RAW);

        // count beyond capacity saturates
        write_slot_count(11'd2047);
        queue_req(REQ_CREATE, '0, '0, PICK_RAW);
        queue_req(REQ_CHECK, '0, '0, PICK_LIVE);

        // single slot: exhaust, recycle
        write_slot_count(11'd1);
        queue_req(REQ_CREATE, '0, '0, PICK_RAW);
        queue_req(REQ_CREATE, '0, '0, PICK_RAW);
        queue_req(REQ_DESTROY, '0, '0, PICK_LIVE);
        queue_req(REQ_EOF, '0, '0, PICK_RAW);
        queue_req(REQ_CREATE, '0, '0, PICK_RAW);

        for (int p = 0; p < 10; p++) begin
            write_slot_count(CFG_W'(phase_count[p]));
            steady = (p == 1);
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 0 && n == phase_items[p] / 2) begin
                    wait_drained();
                end
                handle_requests = {handle_requests, random_request()};
            end
        end

        // overflow the retire list, then return more than fits on the stack
        write_slot_count(11'd1024);
        steady = 1'b0;
        for (int n = 0; n < 8; n++) begin
            queue_req(REQ_CREATE, '0, '0, PICK_RAW);
        end
        for (int n = 0; n < 1030; n++) begin
            queue_req(REQ_DESTROY, 10'($urandom_range(1023)), '0, PICK_MATCH);
        end
        queue_req(REQ_EOF, '0, '0, PICK_RAW);
        for (int n = 0; n < 4; n++) begin
            queue_req(REQ_CREATE, '0, '0, PICK_RAW);
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
